// ----- rtl/rc6_pkg.sv -----
// ----------------------------------------------------------------------------
// rc6_pkg: shared constants and types for the RC6-32/20 block cipher
// Round count, key length, magic constants and controller/datapath signals.
// ----------------------------------------------------------------------------
package rc6_pkg;
  localparam int unsigned Rounds   = 20;
  localparam int unsigned KeyBytes = 16;
  localparam int unsigned RkCount  = 2 * Rounds + 4;
  localparam int unsigned KeyWords = (KeyBytes + 3) / 4;
  localparam int unsigned MixSteps = 3 * ((RkCount > KeyWords) ? RkCount : KeyWords);
  localparam int unsigned RkW      = $clog2(RkCount);
  localparam int unsigned LwW      = (KeyWords > 1) ? $clog2(KeyWords) : 1;
  localparam int unsigned StepW    = $clog2(MixSteps + 1);
  localparam int unsigned RndW     = $clog2(Rounds + 2);
  localparam logic [31:0] MagicP   = 32'hB7E15163;
  localparam logic [31:0] MagicQ   = 32'h9E3779B9;

  localparam logic [1:0] CfgKey0 = 2'd0;

  typedef struct packed {
    logic key_init;   // load key words, set round key counter
    logic fill;       // write P + i*Q at rk index
    logic mix;        // one mixing phase (read, or compute and write)
    logic blk_load;   // load block and apply pre-whitening
    logic blk_round;  // one cipher round
    logic blk_final;  // post-whitening
  } rc6_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mix_last;
    logic round_last;
  } rc6_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction
endpackage

// ----- rtl/rc6_block_cipher.sv -----
// ----------------------------------------------------------------------------
// rc6_block_cipher: RC6-32/20 encrypt/decrypt core with register-held key
// Flow: a block is loaded, whitened, run through 20 rounds on the single round
// unit and whitened again, then held until accepted; one block in flight, so a
// new block is taken only after the previous result has been handed off.
// Reset: key clears to zero and the schedule runs (key load, 44-word fill, 132
// mixing steps); input is held off until it finishes, and again after key writes.
// ----------------------------------------------------------------------------
module rc6_block_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // word_a, word_b, word_c, word_d
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // out_a, out_b, out_c, out_d
);
  logic [63:0] key_q [4];
  rc6_pkg::rc6_cmd_t cmd;
  rc6_pkg::rc6_sts_t sts;

  // key registers; a write triggers re-expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  rc6_ctrl u_ctrl (
    .clk_i, .rst_ni, .rekey_i(cfg_we_i),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts));

  rc6_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .key_i({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .dec_i(s_axis_tuser), .blk_i(s_axis_tdata), .blk_o(m_axis_tdata));
endmodule

// ----- rtl/rc6_ram.sv -----
// ----------------------------------------------------------------------------
// rc6_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rc6_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/rc6_datapath.sv -----
// ----------------------------------------------------------------------------
// rc6_datapath: key schedule and round datapath
// Two round key RAMs, key word array, block registers and one round unit.
// ----------------------------------------------------------------------------
module rc6_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc6_pkg::rc6_cmd_t cmd_i,
  output rc6_pkg::rc6_sts_t sts_o,
  input  logic [255:0]      key_i,
  input  logic              dec_i,
  input  logic [127:0]      blk_i,
  output logic [127:0]      blk_o
);
  localparam int unsigned RkW = rc6_pkg::RkW;

  // Two RAMs hold identical round keys so that whitening can read two words.
  logic [RkW-1:0] ptr_q, ptr_d;
  logic [RkW-1:0] ra0, ra1;
  logic [31:0]    rk0, rk1;
  logic [31:0]    rk_wdata;
  logic           rk_we;
  logic [31:0]    fill_q, fill_d;
  logic [31:0]    ka_q, ka_d, kb_q, kb_d;
  logic [31:0]    lw_q [rc6_pkg::KeyWords];
  logic [rc6_pkg::LwW-1:0]   j_q, j_d;
  logic [rc6_pkg::StepW-1:0] step_q, step_d;
  logic [rc6_pkg::RndW-1:0]  rnd_q, rnd_d;
  logic           mix_phase_q, mix_phase_d;
  logic [31:0]    a_q, b_q, c_q, d_q;
  logic           dec_q;
  logic           round_act_q;

  rc6_ram #(.Width(32), .Depth(rc6_pkg::RkCount)) u_ram0 (
    .clk_i, .we_i(rk_we), .waddr_i(ptr_q), .wdata_i(rk_wdata),
    .raddr_i(ra0), .rdata_o(rk0));
  rc6_ram #(.Width(32), .Depth(rc6_pkg::RkCount)) u_ram1 (
    .clk_i, .we_i(rk_we), .waddr_i(ptr_q), .wdata_i(rk_wdata),
    .raddr_i(ra1), .rdata_o(rk1));

  // Mixing: phase 0 reads S[i], phase 1 computes and writes.
  logic [31:0] mix_a, mix_b, lw_cur;
  logic [31:0] tb, td, t_enc, u_enc, t_dec, u_dec;
  logic [31:0] b2, d2;
  always_comb begin
    lw_cur = lw_q[j_q];
    mix_a  = rc6_pkg::rotl(rk0 + ka_q + kb_q, 5'd3);
    mix_b  = rc6_pkg::rotl(lw_cur + mix_a + kb_q, 5'((mix_a + kb_q) & 32'd31));
  end

  // Round functions
  always_comb begin
    b2    = b_q * ({b_q[30:0], 1'b0} + 32'd1);
    d2    = d_q * ({d_q[30:0], 1'b0} + 32'd1);
    t_enc = rc6_pkg::rotl(b2, 5'd5);
    u_enc = rc6_pkg::rotl(d2, 5'd5);
    // decrypt round operates on the rotated view (a<-d,b<-a,c<-b,d<-c)
    tb    = a_q * ({a_q[30:0], 1'b0} + 32'd1);
    td    = c_q * ({c_q[30:0], 1'b0} + 32'd1);
    t_dec = rc6_pkg::rotl(tb, 5'd5);
    u_dec = rc6_pkg::rotl(td, 5'd5);
  end

  always_comb begin
    ptr_d = ptr_q; fill_d = fill_q; ka_d = ka_q; kb_d = kb_q; j_d = j_q;
    step_d = step_q; rnd_d = rnd_q; mix_phase_d = mix_phase_q;
    rk_we = 1'b0; rk_wdata = fill_q;
    ra0 = ptr_q; ra1 = ptr_q;
    if (cmd_i.key_init) begin
      ptr_d = '0; fill_d = rc6_pkg::MagicP; ka_d = '0; kb_d = '0; j_d = '0;
      step_d = '0; mix_phase_d = 1'b0;
    end else if (cmd_i.fill) begin
      rk_we = 1'b1; rk_wdata = fill_q; fill_d = fill_q + rc6_pkg::MagicQ;
      if (ptr_q == RkW'(rc6_pkg::RkCount - 1)) ptr_d = '0;
      else ptr_d = ptr_q + 1'b1;
    end else if (cmd_i.mix) begin
      mix_phase_d = ~mix_phase_q;
      if (mix_phase_q) begin
        rk_we = 1'b1; rk_wdata = mix_a;
        ka_d = mix_a; kb_d = mix_b;
        step_d = step_q + 1'b1;
        if (ptr_q == RkW'(rc6_pkg::RkCount - 1)) ptr_d = '0;
        else ptr_d = ptr_q + 1'b1;
        if (j_q == rc6_pkg::LwW'(rc6_pkg::KeyWords - 1)) j_d = '0;
        else j_d = j_q + 1'b1;
      end
    end
    // block addressing: rk0/rk1 ready the cycle after the address is set
    if (cmd_i.blk_load) begin
      // entry whitening keys
      rnd_d = '0;
      ra0 = dec_i ? RkW'(2 * rc6_pkg::Rounds + 2) : RkW'(0);
      ra1 = dec_i ? RkW'(2 * rc6_pkg::Rounds + 3) : RkW'(1);
    end else if (round_act_q) begin
      // keys of the first round, fetched during entry whitening
      ra0 = dec_q ? RkW'(2 * rc6_pkg::Rounds) : RkW'(2);
      ra1 = dec_q ? RkW'(2 * rc6_pkg::Rounds + 1) : RkW'(3);
    end else if (cmd_i.blk_round) begin
      rnd_d = rnd_q + 1'b1;
      if (rnd_q == rc6_pkg::RndW'(rc6_pkg::Rounds - 1)) begin
        // exit whitening keys
        ra0 = (dec_q) ? RkW'(0) : RkW'(2 * rc6_pkg::Rounds + 2);
        ra1 = (dec_q) ? RkW'(1) : RkW'(2 * rc6_pkg::Rounds + 3);
      end else if (dec_q) begin
        // next round r = Rounds-1-rnd_q
        ra0 = RkW'(2 * (rc6_pkg::Rounds - 1 - 32'(rnd_q)));
        ra1 = RkW'(2 * (rc6_pkg::Rounds - 1 - 32'(rnd_q)) + 1);
      end else begin
        // next round r = rnd_q+2
        ra0 = RkW'(2 * (32'(rnd_q) + 2));
        ra1 = RkW'(2 * (32'(rnd_q) + 2) + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0; fill_q <= '0; ka_q <= '0; kb_q <= '0; j_q <= '0;
      step_q <= '0; rnd_q <= '0; mix_phase_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d; fill_q <= fill_d; ka_q <= ka_d; kb_q <= kb_d; j_q <= j_d;
      step_q <= step_d; rnd_q <= rnd_d; mix_phase_q <= mix_phase_d;
    end
  end

  // key word array
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_init) begin
      for (int w = 0; w < rc6_pkg::KeyWords; w++) begin
        for (int k = 0; k < 4; k++) begin
          lw_q[w][8*k +: 8] <= (4*w + k < rc6_pkg::KeyBytes) ? key_i[8*(4*w+k) +: 8] : 8'h00;
        end
      end
    end else if (cmd_i.mix && mix_phase_q) begin
      lw_q[j_q] <= mix_b;
    end
  end

  // block registers; each step uses the keys addressed in the cycle before it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) round_act_q <= 1'b0;
    else round_act_q <= cmd_i.blk_load;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      dec_q <= dec_i;
      a_q <= blk_i[31:0]; b_q <= blk_i[63:32];
      c_q <= blk_i[95:64]; d_q <= blk_i[127:96];
    end else if (round_act_q) begin
      // whitening on entry
      if (dec_q) begin
        a_q <= a_q - rk0; c_q <= c_q - rk1;
      end else begin
        b_q <= b_q + rk0; d_q <= d_q + rk1;
      end
    end else if (cmd_i.blk_round) begin
      if (dec_q) begin
        // a<-d,b<-a,c<-b,d<-c then update c and a
        a_q <= rc6_pkg::rotr(d_q - rk0, u_dec[4:0]) ^ t_dec;
        b_q <= a_q;
        c_q <= rc6_pkg::rotr(b_q - rk1, t_dec[4:0]) ^ u_dec;
        d_q <= c_q;
      end else begin
        a_q <= b_q;
        b_q <= rc6_pkg::rotl(c_q ^ u_enc, t_enc[4:0]) + rk1;
        c_q <= d_q;
        d_q <= rc6_pkg::rotl(a_q ^ t_enc, u_enc[4:0]) + rk0;
      end
    end else if (cmd_i.blk_final) begin
      if (dec_q) begin
        b_q <= b_q - rk0; d_q <= d_q - rk1;
      end else begin
        a_q <= a_q + rk0; c_q <= c_q + rk1;
      end
    end
  end

  assign sts_o.fill_last  = (ptr_q == RkW'(rc6_pkg::RkCount - 1));
  assign sts_o.mix_last   = mix_phase_q && (step_q == rc6_pkg::StepW'(rc6_pkg::MixSteps - 1));
  assign sts_o.round_last = (rnd_q == rc6_pkg::RndW'(rc6_pkg::Rounds - 1));
  assign blk_o = {d_q, c_q, b_q, a_q};
endmodule

// ----- rtl/rc6_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc6_ctrl: sequencer for key expansion and block processing
// Runs the schedule after reset and each key write, then rounds per block.
// ----------------------------------------------------------------------------
module rc6_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rekey_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rc6_pkg::rc6_cmd_t cmd_o,
  input  rc6_pkg::rc6_sts_t sts_i
);
  localparam logic [2:0] StInit  = 3'd0;
  localparam logic [2:0] StFill  = 3'd1;
  localparam logic [2:0] StMix   = 3'd2;
  localparam logic [2:0] StIdle  = 3'd3;
  localparam logic [2:0] StWhite = 3'd4;
  localparam logic [2:0] StRound = 3'd5;
  localparam logic [2:0] StFinal = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q | rekey_i;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StInit: begin
        cmd_o.key_init = 1'b1; pend_d = rekey_i; state_d = StFill;
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) state_d = StMix;
      end
      StMix: begin
        cmd_o.mix = 1'b1;
        if (sts_i.mix_last) state_d = pend_d ? StInit : StIdle;
      end
      StIdle: begin
        in_ready_o = !pend_q;
        if (pend_q) state_d = StInit;
        else if (in_valid_i) begin
          cmd_o.blk_load = 1'b1; state_d = StWhite;
        end
      end
      StWhite: state_d = StRound;
      StRound: begin
        cmd_o.blk_round = 1'b1;
        if (sts_i.round_last) state_d = StFinal;
      end
      StFinal: begin
        cmd_o.blk_final = 1'b1; state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StInit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; pend_q <= pend_d;
    end
  end
endmodule
